@@ rtl/dfst_pkg.sv @@
// ============================================================================
// dfst_pkg
// Shared types, constants and text tables of the symbol-list tokenizer.
// ============================================================================
package dfst_pkg;

    // width of the running symbol counter (saturating)
    localparam int COUNT_BITS     = 16;
    // width of the count field on the result channel
    localparam int OUT_COUNT_BITS = 16;
    // compare width used when narrowing the counter to the result field
    localparam int CNT_WIDE       = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

    // header strings, both eight bytes long
    localparam int          MATCH_LEN = 8;
    localparam int          POS_BITS  = $clog2(MATCH_LEN);
    localparam logic [63:0] EXP_TEXT  = "EXPORTS\n";
    localparam logic [63:0] IMP_TEXT  = "IMPORTS\n";

    // results of one byte: up to seven replayed bytes, the byte itself,
    // a closing terminator and the end-of-list result
    localparam int IDX_BITS = 4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_TERM = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // what the current byte itself contributes
    typedef enum logic [1:0] {
        BK_NONE = 2'd0,
        BK_CHAR = 2'd1,
        BK_TERM = 2'd2
    } t_bkind;

    typedef enum logic [5:0] {
        MODE_HEADER   = 6'b000001,
        MODE_SKIPWS   = 6'b000010,
        MODE_IMPMATCH = 6'b000100,
        MODE_SYMBOL   = 6'b001000,
        MODE_DISCARD  = 6'b010000,
        MODE_DONE     = 6'b100000
    } t_mode;

    // result plan of one request, walked by the emitter
    typedef struct packed {
        logic                      rep_imp;   // replay text: 1 imports, 0 exports
        logic [POS_BITS-1:0]       rep_len;   // replayed header bytes
        t_bkind                    byte_kind;
        logic [7:0]                byte_val;
        logic                      eof_term;  // terminator for a symbol open at eof
        logic                      list_end;
        logic [OUT_COUNT_BITS-1:0] count;
    } t_plan;

    function automatic logic [7:0] exp_char(input logic [POS_BITS-1:0] idx);
        return EXP_TEXT[(MATCH_LEN - 1 - int'(idx)) * 8 +: 8];
    endfunction

    function automatic logic [7:0] imp_char(input logic [POS_BITS-1:0] idx);
        return IMP_TEXT[(MATCH_LEN - 1 - int'(idx)) * 8 +: 8];
    endfunction

endpackage

@@ rtl/dfst_parser.sv @@
// ============================================================================
// dfst_parser
// Parse state and per-byte result plan of the symbol-list tokenizer.
// ============================================================================
module dfst_parser import dfst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_file,
    output t_plan      o_plan,
    output logic       o_plan_live
);

    t_mode                 r_mode, n_mode, h_mode, f_mode;
    logic [POS_BITS-1:0]   r_mpos, n_mpos, h_mpos, f_mpos;
    logic [COUNT_BITS-1:0] r_total, n_total, tot_inc;
    logic [CNT_WIDE-1:0]   tot_wide;
    logic                  inc, feed, ws;
    t_plan                 plan;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    assign ws = is_ws(i_in_byte);

    always_comb begin
        h_mode         = r_mode;
        h_mpos         = r_mpos;
        inc            = 1'b0;
        feed           = 1'b0;
        plan.rep_imp   = 1'b0;
        plan.rep_len   = '0;
        plan.byte_kind = BK_NONE;
        plan.byte_val  = i_in_byte;
        plan.eof_term  = 1'b0;
        plan.list_end  = 1'b0;
        plan.count     = '0;

        // header match at start of file
        case (r_mode)
            MODE_HEADER: begin
                if (i_in_byte == exp_char(r_mpos)) begin
                    if (r_mpos == POS_BITS'(MATCH_LEN - 1)) begin
                        h_mode = MODE_SKIPWS;
                        h_mpos = '0;
                    end else begin
                        h_mpos = r_mpos + 1'b1;
                    end
                end else begin
                    // held bytes start a symbol, then the byte is fed
                    if (r_mpos != '0) begin
                        plan.rep_len = r_mpos;
                        inc          = 1'b1;
                        h_mode       = MODE_SYMBOL;
                    end else begin
                        h_mode = MODE_SKIPWS;
                    end
                    h_mpos = '0;
                    feed   = 1'b1;
                end
            end
            MODE_SKIPWS, MODE_IMPMATCH, MODE_SYMBOL, MODE_DISCARD: feed = 1'b1;
            MODE_DONE: ;
            default: h_mode = MODE_DONE;
        endcase

        // ordinary byte handling
        f_mode = h_mode;
        f_mpos = h_mpos;
        if (feed) begin
            case (h_mode)
                MODE_SKIPWS: begin
                    if (!ws) begin
                        if (i_in_byte == imp_char('0)) begin
                            f_mode = MODE_IMPMATCH;
                            f_mpos = POS_BITS'(1);
                        end else begin
                            inc            = 1'b1;
                            plan.byte_kind = BK_CHAR;
                            f_mode         = MODE_SYMBOL;
                        end
                    end
                end
                MODE_IMPMATCH: begin
                    if (i_in_byte == imp_char(h_mpos)) begin
                        if (h_mpos == POS_BITS'(MATCH_LEN - 1)) begin
                            f_mode = MODE_DONE;
                            f_mpos = '0;
                        end else begin
                            f_mpos = h_mpos + 1'b1;
                        end
                    end else begin
                        // partial import header becomes a symbol
                        plan.rep_imp = 1'b1;
                        plan.rep_len = h_mpos;
                        inc          = 1'b1;
                        f_mpos       = '0;
                        if (ws) begin
                            plan.byte_kind = BK_TERM;
                            f_mode = (i_in_byte == CH_LF) ? MODE_SKIPWS : MODE_DISCARD;
                        end else begin
                            plan.byte_kind = BK_CHAR;
                            f_mode         = MODE_SYMBOL;
                        end
                    end
                end
                MODE_SYMBOL: begin
                    if (ws) begin
                        plan.byte_kind = BK_TERM;
                        f_mode = (i_in_byte == CH_LF) ? MODE_SKIPWS : MODE_DISCARD;
                    end else begin
                        plan.byte_kind = BK_CHAR;
                    end
                end
                MODE_DISCARD: begin
                    if (i_in_byte == CH_LF) begin
                        f_mode = MODE_SKIPWS;
                    end
                end
                default: ;
            endcase
        end

        // end of file: flush held header bytes, close symbol, end the list
        n_mode = f_mode;
        n_mpos = f_mpos;
        if (i_end_of_file) begin
            if (f_mode == MODE_HEADER || f_mode == MODE_IMPMATCH) begin
                plan.rep_imp = (f_mode == MODE_IMPMATCH);
                plan.rep_len = f_mpos;
                inc          = 1'b1;
                plan.eof_term = 1'b1;
            end else if (f_mode == MODE_SYMBOL) begin
                plan.eof_term = 1'b1;
            end
            plan.list_end = 1'b1;
            n_mode        = MODE_HEADER;
            n_mpos        = '0;
        end
    end

    assign tot_inc  = (inc && (r_total != '1)) ? r_total + 1'b1 : r_total;
    assign tot_wide = CNT_WIDE'(tot_inc);
    assign n_total  = i_end_of_file ? '0 : tot_inc;

    always_comb begin
        o_plan = plan;
        if (!plan.list_end) begin
            o_plan.count = '0;
        end else if (tot_wide > CNT_WIDE'({OUT_COUNT_BITS{1'b1}})) begin
            o_plan.count = '1;
        end else begin
            o_plan.count = OUT_COUNT_BITS'(tot_wide);
        end
    end

    assign o_plan_live = (plan.rep_len != '0) || (plan.byte_kind != BK_NONE) ||
                         plan.eof_term || plan.list_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HEADER;
            r_mpos  <= '0;
            r_total <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_mpos  <= n_mpos;
            r_total <= n_total;
        end
    end

`ifndef SYNTH
    // the last byte of a file returns all parse state to reset
    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_file) |=>
            (r_mode == MODE_HEADER && r_mpos == '0 && r_total == '0))
        else $error("parse state not cleared after end of file");

    a_mode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_mode))
        else $error("parse mode not one-hot");

    // match position only held while a header is being matched
    a_mpos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_HEADER && r_mode != MODE_IMPMATCH) |-> (r_mpos == '0))
        else $error("match position held outside header match");
`endif

endmodule

@@ rtl/dfst_emitter.sv @@
// ============================================================================
// dfst_emitter
// Holds one result plan and walks it into the output register, one result
// per cycle while i_stall does not hold the output register.
// ============================================================================
module dfst_emitter import dfst_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  t_plan                     i_plan,
    output logic                      o_hold,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic [7:0]                o_out_byte,
    output t_kind                     o_kind,
    output logic [OUT_COUNT_BITS-1:0] o_symbol_count,
    output logic                      o_last_of_run
);

    t_plan                     r_plan;
    logic                      r_plan_valid;
    logic [IDX_BITS-1:0]       r_idx, tail, total;
    logic                      r_out_valid, r_out_last;
    logic [7:0]                r_out_byte, sel_byte;
    t_kind                     r_out_kind, sel_kind;
    logic [OUT_COUNT_BITS-1:0] r_out_count, sel_count;
    logic                      b_present, out_free, adv, fin, sel_last;

    assign b_present = (r_plan.byte_kind != BK_NONE);
    assign total     = IDX_BITS'(r_plan.rep_len) + IDX_BITS'(b_present) +
                       IDX_BITS'(r_plan.eof_term) + IDX_BITS'(r_plan.list_end);
    assign tail      = r_idx - IDX_BITS'(r_plan.rep_len);
    assign sel_last  = (r_idx == total - 1'b1);

    // order: replayed bytes, the byte itself, eof terminator, end of list
    always_comb begin
        sel_byte  = 8'h00;
        sel_kind  = KIND_END;
        sel_count = '0;
        if (r_idx < IDX_BITS'(r_plan.rep_len)) begin
            sel_byte = r_plan.rep_imp ? imp_char(r_idx[POS_BITS-1:0])
                                      : exp_char(r_idx[POS_BITS-1:0]);
            sel_kind = KIND_CHAR;
        end else if (b_present && tail == '0) begin
            if (r_plan.byte_kind == BK_CHAR) begin
                sel_byte = r_plan.byte_val;
                sel_kind = KIND_CHAR;
            end else begin
                sel_kind = KIND_TERM;
            end
        end else if (r_plan.eof_term && tail == IDX_BITS'(b_present)) begin
            sel_kind = KIND_TERM;
        end else begin
            sel_count = r_plan.count;
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_plan_valid && out_free;
    assign fin      = adv && sel_last;
    assign o_hold   = r_plan_valid && !fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plan_valid <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_load) begin
                r_plan_valid <= 1'b1;
                r_idx        <= '0;
            end else if (fin) begin
                r_plan_valid <= 1'b0;
            end else if (adv) begin
                r_idx <= r_idx + 1'b1;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_plan <= i_plan;
        end
        if (adv) begin
            r_out_byte  <= sel_byte;
            r_out_kind  <= sel_kind;
            r_out_count <= sel_count;
            r_out_last  <= sel_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_kind         = r_out_kind;
    assign o_symbol_count = r_out_count;
    assign o_last_of_run  = r_out_last;

`ifndef SYNTH
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plan_valid |-> (r_idx < total))
        else $error("result index ran past its plan");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_END) |-> r_out_last)
        else $error("end of list not last of its run");

    a_run_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_plan_valid)
        else $error("run cut short: no plan behind a non-final result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !o_hold)
        else $error("plan loaded over a run still in progress");
`endif

endmodule

@@ rtl/def_file_symbol_tokenizer_unit.sv @@
// ============================================================================
// def_file_symbol_tokenizer_unit
// Symbol-list file tokenizer: bytes in, symbol bytes, terminators and one
// end-of-list result with the symbol count out.
// ============================================================================
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  input    | in        | i_valid / o_stall  | i_in_byte, i_end_of_file
//  result   | out       | o_valid / i_stall  | o_out_byte, o_kind, o_symbol_count,
//           |           |                    | o_last_of_run
//
//  While i_stall is low, a request giving at most one result is taken every
//  cycle; one giving k results, k up to 10, holds o_stall until the emitter
//  has moved its last result (one result per cycle while i_stall is low, from
//  its plan register into the output register). The first result reaches
//  o_valid through the plan register and then the output register.
//  Reset is synchronous, active low; it clears parse state, the plan and
//  the output valid. i_stall holds the output register and, once the plan
//  register is occupied, backs up into o_stall.
//
module def_file_symbol_tokenizer_unit import dfst_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_in_byte,
    input  logic                      i_end_of_file,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_out_byte,
    output logic [1:0]                o_kind,
    output logic [OUT_COUNT_BITS-1:0] o_symbol_count,
    output logic                      o_last_of_run
);

    t_plan plan;
    logic  plan_live, hold, accept;
    t_kind kind;

    // a request is taken when the plan register is free or drains this cycle
    assign accept  = i_valid && !hold;
    assign o_stall = hold;

    // header matching, whitespace skipping, symbol counting
    dfst_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_file (i_end_of_file),
        .o_plan        (plan),
        .o_plan_live   (plan_live)
    );

    // requests with no results (whitespace, header bytes) never fill the plan
    dfst_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept && plan_live),
        .i_plan         (plan),
        .o_hold         (hold),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_kind         (kind),
        .o_symbol_count (o_symbol_count),
        .o_last_of_run  (o_last_of_run)
    );

    assign o_kind = kind;

endmodule
